// File: rtl/core/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants and types of the rational sum accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int TERM_WIDTH_DEF = 32;
    localparam int WORD_W         = 64;
    localparam int DEN_OUT_W      = 63;
    localparam int CNT_W          = 7;

    localparam logic [WORD_W-1:0] MAXMAG = {1'b0, {(WORD_W-1){1'b1}}};

    // Request and response of the shared divider.
    typedef struct packed {
        logic            start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } t_div_rsp;

endpackage

// File: rtl/core/rsa_divider.sv
// ----------------------------------------------------------------------------
// rsa_divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsa_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsa_pkg::t_div_req i_req,
    output rsa_pkg::t_div_rsp o_rsp
);
    import rsa_pkg::*;

    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORD_W:0]   w_shift;
    logic [WORD_W:0]   w_diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[WORD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[WORD_W]) begin
                    r_rem <= w_diff[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// File: rtl/core/rational_sum_accumulator_unit.sv
// ----------------------------------------------------------------------------
// rational_sum_accumulator_unit
// Accumulates fraction terms, reducing by Euclidean gcd, and reports the sum.
// ----------------------------------------------------------------------------
// A term runs two gcd loops (up to about 46 and 92 steps), four reducing
// divisions on the shared divider and three products; a zero denominator skips
// them, and a last term adds a division for the whole/frac split.
// Throughput: one term at a time; s_axis_tready is high only when the sequencer
// is idle and no result waits. Reset (sync, active low) clears the sum and flag.
module rational_sum_accumulator_unit #(
    parameter int TERM_WIDTH = rsa_pkg::TERM_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: term_numerator [31:0], term_denominator [62:32], zero pad [63]
    input  logic [63:0]   s_axis_tdata,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: whole_part [63:0], frac_numerator [127:64], frac_denominator
    // [190:128], zero pad [191]
    output logic [191:0]  m_axis_tdata,
    // tuser: error_flag
    output logic          m_axis_tuser
);
    import rsa_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_G1    = 4'd1;  // gcd of the term
    localparam logic [3:0] ST_R1N   = 4'd2;  // divide numerator by gcd
    localparam logic [3:0] ST_R1D   = 4'd3;  // divide denominator by gcd
    localparam logic [3:0] ST_M1    = 4'd4;  // products and overflow checks
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_ADD   = 4'd7;
    localparam logic [3:0] ST_G2    = 4'd8;  // gcd of the sum
    localparam logic [3:0] ST_R2N   = 4'd9;
    localparam logic [3:0] ST_R2D   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11; // whole/frac split
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_CHK   = 4'd13; // decide after term
    localparam logic [3:0] ST_MW    = 4'd14; // multiply in progress

    logic [3:0]         r_st;
    logic               r_wait;
    logic [WORD_W-1:0]  r_sum_num, r_sum_den;
    logic               r_err;
    logic               r_last;
    logic [WORD_W-1:0]  r_a, r_b;      // gcd operands
    logic [WORD_W-1:0]  r_g;
    logic [WORD_W-1:0]  r_tmag, r_den;
    logic               r_tneg;
    logic [WORD_W-1:0]  r_p1, r_p2, r_nd;
    logic [WORD_W-1:0]  r_rmag;
    logic               r_rneg;
    logic [1:0]         r_mi;          // which product
    logic [2:0]         r_mstep;
    logic [WORD_W-1:0]  r_ma, r_mb;
    logic [127:0]       r_macc;
    logic               r_ovf;
    logic               r_otv;
    logic [191:0]       r_odata;
    logic               r_ouser;

    t_div_req           r_div_req;
    t_div_rsp           w_rsp;

    logic [TERM_WIDTH-1:0]   w_nraw;
    logic [TERM_WIDTH-1:0]   w_nmag;
    logic [TERM_WIDTH-2:0]   w_draw;
    logic                    w_sneg;
    logic [WORD_W-1:0]       w_smag;
    logic [31:0]             w_mbh;
    logic [6:0]              w_psh;
    logic [63:0]             w_pp;

    rsa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div_req),
        .o_rsp  (w_rsp)
    );

    // Input decoding, sum magnitude and one 16x32 partial product.
    always_comb begin
        w_nraw = s_axis_tdata[TERM_WIDTH-1:0];
        w_nmag = w_nraw[TERM_WIDTH-1] ? (~w_nraw + 1'b1) : w_nraw;
        w_draw = s_axis_tdata[32 +: (TERM_WIDTH-1)];
        w_sneg = r_sum_num[WORD_W-1];
        w_smag = w_sneg ? (~r_sum_num + 1'b1) : r_sum_num;
        w_mbh  = r_mstep[2] ? r_mb[63:32] : r_mb[31:0];
        w_pp   = r_ma[r_mstep[1:0]*16 +: 16] * w_mbh;
        w_psh  = 7'({r_mstep[1:0], 4'd0}) + 7'({r_mstep[2], 5'd0});
    end

    assign s_axis_tready = (r_st == ST_IDLE) && !r_otv;
    assign m_axis_tvalid = r_otv;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // Main sequencer: all divisions go through the shared divider, products
    // through a 16x32 partial-product multiplier (8 passes per product).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_wait    <= 1'b0;
            r_sum_num <= '0;
            r_sum_den <= 64'd1;
            r_err     <= 1'b0;
            r_otv     <= 1'b0;
            r_div_req <= '0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_otv && m_axis_tready) begin
                r_otv <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_last <= s_axis_tlast;
                        r_tneg <= w_nraw[TERM_WIDTH-1];
                        r_tmag <= WORD_W'(w_nmag);
                        r_den  <= WORD_W'(w_draw);
                        r_a    <= WORD_W'(w_nmag);
                        r_b    <= WORD_W'(w_draw);
                        r_wait <= 1'b0;
                        if (w_draw == '0) begin
                            r_err <= 1'b1;
                            r_st  <= ST_CHK;
                        end else begin
                            r_st  <= ST_G1;
                        end
                    end
                end
                ST_G1, ST_G2: begin
                    // Euclid: a,b <- b, a mod b until b is zero.
                    if (!r_wait) begin
                        if (r_b == '0) begin
                            r_g <= (r_a == '0) ? 64'd1 : r_a;
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= (r_st == ST_G1) ? r_tmag : r_rmag;
                            r_div_req.divisor  <= (r_a == '0) ? 64'd1 : r_a;
                            r_wait <= 1'b0;
                            r_st   <= (r_st == ST_G1) ? ST_R1N : ST_R2N;
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= r_a;
                            r_div_req.divisor  <= r_b;
                            r_wait <= 1'b1;
                        end
                    end else if (w_rsp.done) begin
                        r_a    <= r_b;
                        r_b    <= w_rsp.remainder;
                        r_wait <= 1'b0;
                    end
                end
                ST_R1N, ST_R2N: begin
                    if (w_rsp.done) begin
                        if (r_st == ST_R1N) r_tmag <= w_rsp.quotient;
                        else                r_rmag <= w_rsp.quotient;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= (r_st == ST_R1N) ? r_den : r_nd;
                        r_div_req.divisor  <= r_g;
                        r_st <= (r_st == ST_R1N) ? ST_R1D : ST_R2D;
                    end
                end
                ST_R1D: begin
                    if (w_rsp.done) begin
                        r_den  <= w_rsp.quotient;
                        r_tneg <= r_tneg && (r_tmag != '0);
                        r_ovf  <= 1'b0;
                        r_mi   <= 2'd0;
                        r_st   <= ST_M1;
                    end
                end
                ST_M1, ST_M2, ST_M3: begin
                    // Load one product: tmag*sum_den, smag*den, den*sum_den.
                    r_ma    <= (r_st == ST_M1) ? r_tmag :
                               (r_st == ST_M2) ? w_smag : r_den;
                    r_mb    <= (r_st == ST_M2) ? r_den : r_sum_den;
                    r_macc  <= '0;
                    r_mstep <= 3'd0;
                    r_mi    <= (r_st == ST_M1) ? 2'd0 :
                               (r_st == ST_M2) ? 2'd1 : 2'd2;
                    r_st    <= ST_MW;
                end
                ST_MW: begin
                    // Eight passes cover every 16-bit slice of a against both
                    // 32-bit halves of b; the full product is then range checked.
                    if (!r_wait) begin
                        r_macc  <= r_macc + (128'(w_pp) << w_psh);
                        r_mstep <= r_mstep + 1'b1;
                        if (r_mstep == 3'd7) r_wait <= 1'b1;
                    end else begin
                        r_wait <= 1'b0;
                        if (r_macc[127:63] != '0) begin
                            r_ovf <= 1'b1;
                        end
                        unique case (r_mi)
                            2'd0:    begin r_p1 <= r_macc[63:0]; r_st <= ST_M2; end
                            2'd1:    begin r_p2 <= r_macc[63:0]; r_st <= ST_M3; end
                            default: begin r_nd <= r_macc[63:0]; r_st <= ST_ADD; end
                        endcase
                    end
                end
                ST_ADD: begin
                    if (r_ovf) begin
                        r_err <= 1'b1;
                        r_st  <= ST_CHK;
                    end else if (r_tneg == w_sneg) begin
                        if (r_p1 > MAXMAG - r_p2) begin
                            r_err <= 1'b1;
                            r_st  <= ST_CHK;
                        end else begin
                            r_rmag <= r_p1 + r_p2;
                            r_rneg <= r_tneg;
                            r_a    <= r_p1 + r_p2;
                            r_b    <= r_nd;
                            r_st   <= ST_G2;
                        end
                    end else if (r_p1 >= r_p2) begin
                        r_rmag <= r_p1 - r_p2;
                        r_rneg <= r_tneg;
                        r_a    <= r_p1 - r_p2;
                        r_b    <= r_nd;
                        r_st   <= ST_G2;
                    end else begin
                        r_rmag <= r_p2 - r_p1;
                        r_rneg <= w_sneg;
                        r_a    <= r_p2 - r_p1;
                        r_b    <= r_nd;
                        r_st   <= ST_G2;
                    end
                end
                ST_R2D: begin
                    if (w_rsp.done) begin
                        r_sum_num <= (r_rneg && r_rmag != '0) ?
                                     (~r_rmag + 1'b1) : r_rmag;
                        r_sum_den <= w_rsp.quotient;
                        r_st      <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (!r_last) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_smag;
                        r_div_req.divisor  <= (r_sum_den == '0) ? 64'd1 : r_sum_den;
                        r_st <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_rsp.done) begin
                        r_odata[63:0]    <= w_sneg ? (~w_rsp.quotient + 1'b1) :
                                            w_rsp.quotient;
                        r_odata[127:64]  <= w_sneg ? (~w_rsp.remainder + 1'b1) :
                                            w_rsp.remainder;
                        r_odata[190:128] <= (r_sum_den == '0) ? 63'd1 :
                                            r_sum_den[DEN_OUT_W-1:0];
                        r_odata[191]     <= 1'b0;
                        r_ouser   <= r_err;
                        r_st      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_otv) begin
                        r_otv     <= 1'b1;
                        r_sum_num <= '0;
                        r_sum_den <= 64'd1;
                        r_err     <= 1'b0;
                        r_st      <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_IDLE |-> r_sum_den != '0)
        else $error("sum denominator is zero");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !s_axis_tready)
        else $error("ready while busy");
`endif

endmodule

// File: dv/rational_sum_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// rational_sum_accumulator_unit_test
// Drives fraction terms into the accumulator and checks each reported sum
// against a cycle-free predictor of the gcd-reduced running sum.
// ----------------------------------------------------------------------------
module rational_sum_accumulator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_LIMIT = 400000;

    typedef struct packed {
        logic [63:0] whole;
        logic [63:0] rem;
        logic [62:0] den;
        logic        err;
    } sum_report_t;

    // Predictor of the running sum and queue of pending sum reports.
    class sum_scoreboard;
        logic [63:0] acc_num;
        logic [63:0] acc_den;
        logic        acc_err;
        sum_report_t pending[$];
        int          mismatches;
        int          reports_checked;

        function new();
            clear_sum();
            mismatches = 0;
            reports_checked = 0;
        endfunction

        function void clear_sum();
            acc_num = 64'd0;
            acc_den = 64'd1;
            acc_err = 1'b0;
        endfunction

        function logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
            logic [63:0] t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function bit mul_ok(logic [63:0] a, logic [63:0] b, output logic [63:0] p);
            p = 64'd0;
            if (b != 0 && a > MAG_LIMIT / b) return 0;
            p = a * b;
            return 1;
        endfunction

        function void add_term(logic [63:0] tmag, bit tneg, logic [63:0] den);
            bit          sneg;
            bit          rneg;
            logic [63:0] smag, p1, p2, nd, rmag, g;
            sneg = acc_num[63];
            smag = sneg ? -acc_num : acc_num;
            if (!mul_ok(tmag, acc_den, p1) || !mul_ok(smag, den, p2)
                || !mul_ok(den, acc_den, nd)) begin
                acc_err = 1'b1;
                return;
            end
            if (tneg == sneg) begin
                if (p1 > MAG_LIMIT - p2) begin
                    acc_err = 1'b1;
                    return;
                end
                rmag = p1 + p2;
                rneg = tneg;
            end else if (p1 >= p2) begin
                rmag = p1 - p2;
                rneg = tneg;
            end else begin
                rmag = p2 - p1;
                rneg = sneg;
            end
            g = euclid(rmag, nd);
            if (g == 0) g = 1;
            rmag = rmag / g;
            nd = nd / g;
            if (rmag == 0) rneg = 0;
            acc_num = rneg ? -rmag : rmag;
            acc_den = nd;
        endfunction

        // Note one accepted input transaction.
        function void note_term(logic [31:0] num, logic [30:0] den_in, logic last);
            bit          tneg;
            logic [63:0] tmag, den, g, d, q, r, smag;
            sum_report_t rep;
            tneg = num[31];
            tmag = tneg ? {32'd0, -num} : {32'd0, num};
            den = {33'd0, den_in};
            if (den == 0) begin
                acc_err = 1'b1;
            end else begin
                g = euclid(tmag, den);
                tmag = tmag / g;
                den = den / g;
                add_term(tmag, tneg && tmag != 0, den);
            end
            if (!last) return;
            smag = acc_num[63] ? -acc_num : acc_num;
            d = (acc_den == 0) ? 64'd1 : acc_den;
            q = smag / d;
            r = smag % d;
            rep.whole = acc_num[63] ? -q : q;
            rep.rem = acc_num[63] ? -r : r;
            rep.den = d[62:0];
            rep.err = acc_err;
            pending.push_back(rep);
            clear_sum();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            mismatches++;
        endtask

        // Check one accepted output transaction.
        task check_report(logic [191:0] data, logic err);
            sum_report_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected report", data[63:0], 64'd0);
                return;
            end
            want = pending.pop_front();
            reports_checked++;
            if (data[63:0] != want.whole) report_mismatch("whole", data[63:0], want.whole);
            if (data[127:64] != want.rem)
                report_mismatch("remainder", data[127:64], want.rem);
            if (data[190:128] != want.den)
                report_mismatch("denominator", {1'b0, data[190:128]}, {1'b0, want.den});
            if (err != want.err) report_mismatch("error", {63'd0, err}, {63'd0, want.err});
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: term_numerator [31:0], term_denominator [62:32], zero pad [63]
    logic [63:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: whole_part [63:0], frac_numerator [127:64], frac_denominator
    // [190:128], zero pad [191]
    logic [191:0] m_axis_tdata;
    // tuser: error_flag
    logic         m_axis_tuser;

    sum_scoreboard sb;
    int            idle_cycles;
    int            terms_sent;
    bit            stall_enable;

    rational_sum_accumulator_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample both sides at the rising edge; the watchdog counts idle cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_term(s_axis_tdata[31:0], s_axis_tdata[62:32], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_report(m_axis_tdata, m_axis_tuser);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall pattern: stretches of free flow and stretches of random stalls.
    initial begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 300 < 100 || !stall_enable)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(3, 0) != 0);
        end
    end

    // Present one term and hold it until the block takes it.
    task send_term(logic [31:0] num, logic [30:0] den, logic last);
        s_axis_tdata <= {1'b0, den, num};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        terms_sent++;
    endtask

    task pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Numerators mostly small so sums stay exact, sometimes full range.
    function logic [31:0] pick_num();
        case ($urandom_range(5, 0))
            0: return $urandom;
            1: return {$urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            2: return $urandom_range(1, 0) ? -$urandom_range(1000000, 0) : $urandom_range(1000000, 0);
            default: return $urandom_range(1, 0) ? -$urandom_range(100, 0) : $urandom_range(100, 0);
        endcase
    endfunction

    function logic [30:0] pick_den();
        case ($urandom_range(9, 0))
            0: return 31'd0;
            1: return 31'($urandom);
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom_range(100000, 1));
            default: return 31'($urandom_range(60, 1));
        endcase
    endfunction

    initial begin
        int burst;
        sb = new();
        idle_cycles = 0;
        terms_sent = 0;
        stall_enable = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 64'd0;
        s_axis_tlast = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed terms: extremes, zero denominator, overflow, zero sum.
        send_term(32'd0, 31'd1, 1'b1);
        send_term(32'd1, 31'd2, 1'b0);
        send_term(32'd1, 31'd3, 1'b1);
        send_term(32'hFFFF_FFF9, 31'd2, 1'b1);
        send_term(32'd3, 31'd0, 1'b1);
        send_term(32'd5, 31'd7, 1'b0);
        send_term(32'hFFFF_FFFB, 31'd7, 1'b1);
        send_term(32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
        send_term(32'h7FFF_FFFF, 31'h7FFF_FFFE, 1'b1);
        send_term(32'd1, 31'h7FFF_FFFF, 1'b0);
        send_term(32'd1, 31'h7FFF_FFFE, 1'b0);
        send_term(32'd1, 31'h7FFF_FFFD, 1'b0);
        send_term(32'd1, 31'h7FFF_FFFC, 1'b1);
        send_term(32'h8000_0000, 31'd1, 1'b0);
        send_term(32'h8000_0000, 31'd1, 1'b1);
        send_term(32'h7FFF_FFFF, 31'd1, 1'b0);
        send_term(32'h5555_5555, 31'h2AAA_AAAA, 1'b1);
        send_term(32'hAAAA_AAAA, 31'h5555_5555, 1'b1);
        send_term(32'd6, 31'd4, 1'b1);
        send_term(32'd0, 31'd9, 1'b0);
        send_term(32'd0, 31'd0, 1'b1);

        // Random sums of a few terms each, sent in bursts with gaps.
        stall_enable = 1;
        while (terms_sent < 2000) begin
            burst = $urandom_range(12, 1);
            repeat (burst) send_term(pick_num(), pick_den(), $urandom_range(4, 0) == 0);
            if ($urandom_range(2, 0) == 0) pause_sender($urandom_range(20, 1));
        end
        send_term(32'd1, 31'd1, 1'b1);
        s_axis_tvalid <= 1'b0;

        // Drain the remaining reports.
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("Sent %0d terms; checked %0d sum reports including zero-denominator",
                 terms_sent, sb.reports_checked);
        $display("and overflow cases, with random sender gaps and receiver stalls.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog on cycles without any transaction.
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
